FILE: src/dsrq_pkg.sv
// Shared types, constants and tables for the shadow-register write queue.
// Used by the front part, back part, top level and testbench; depends on nothing else.
package dsrq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_VALUES = 18;

	localparam logic [4:0] IDX_UPDATE = 5'd14;
	localparam logic [4:0] IDX_RESET_STROBE = 5'd15;
	localparam logic [4:0] IDX_LATCH_STROBE = 5'd16;
	localparam logic [4:0] IDX_ATTEN = 5'd17;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_FIELD = 3'd1,
		OP_READ = 3'd2,
		OP_MRESET = 3'd3,
		OP_PROFILE = 3'd4,
		OP_PREC = 3'd5,
		OP_EMIT = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_BUS_OFFSET = 2'd1;
	localparam logic [1:0] CFG_DEVICE_BASE = 2'd2;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		op_t op;
		logic [4:0] idx;
		logic [31:0] wv;
		logic [2:0] flo;
		logic [3:0] fw;
		logic line;
		logic level;
		logic idx_ok;
	} item_t;

	// Length of each value in bytes.
	function automatic logic [2:0] val_len(input logic [4:0] i);
		case (i)
			5'd4, 5'd6, 5'd8, 5'd10, 5'd12: val_len = 3'd4;
			5'd5, 5'd7, 5'd9, 5'd11, 5'd13: val_len = 3'd2;
			default: val_len = 3'd1;
		endcase
	endfunction

	// Chip register address of each value.
	function automatic logic [7:0] val_reg(input logic [4:0] i);
		case (i)
			5'd1: val_reg = 8'h01;
			5'd2: val_reg = 8'h02;
			5'd3: val_reg = 8'h03;
			5'd4: val_reg = 8'h04;
			5'd5: val_reg = 8'h08;
			5'd6: val_reg = 8'h0A;
			5'd7: val_reg = 8'h0E;
			5'd8: val_reg = 8'h10;
			5'd9: val_reg = 8'h14;
			5'd10: val_reg = 8'h16;
			5'd11: val_reg = 8'h1A;
			5'd12: val_reg = 8'h1C;
			5'd13: val_reg = 8'h20;
			5'd14: val_reg = 8'h30;
			5'd15: val_reg = 8'h31;
			5'd16: val_reg = 8'h32;
			default: val_reg = 8'h00;
		endcase
	endfunction

endpackage

FILE: src/dsrq_front.sv
// Front part: input skid register that takes one beat and classifies it.
// Depends on dsrq_pkg.
module dsrq_front
	import dsrq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [4:0] value_index,
	input logic [31:0] write_value,
	input logic [2:0] field_low,
	input logic [3:0] field_width,
	input logic profile_line,
	input logic profile_level,
	output logic item_valid,
	output item_t item,
	input logic item_take
);

	logic full_q;
	item_t item_q;

	assign in_stall = full_q && !item_take;
	assign item_valid = full_q;
	assign item = item_q;

	// Control: occupancy of the single-entry slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			full_q <= 1'b1;
		end else if (item_take) begin
			full_q <= 1'b0;
		end
	end

	// Payload capture with index range check.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q.op <= op_t'(op);
			item_q.idx <= value_index;
			item_q.wv <= write_value;
			item_q.flo <= field_low;
			item_q.fw <= field_width;
			item_q.line <= profile_line;
			item_q.level <= profile_level;
			item_q.idx_ok <= (value_index < 5'(NUM_VALUES));
		end
	end

endmodule

FILE: src/dsrq_back.sv
// Back part: shadow store, index ring, and bus word serializer.
// Depends on dsrq_pkg.
module dsrq_back
	import dsrq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input item_t item,
	output logic item_take,
	input logic enable,
	input logic [15:0] bus_offset,
	input logic [7:0] device_base,
	output logic out_valid,
	input logic out_stall,
	output logic bus_valid,
	output logic [15:0] bus_address,
	output logic [15:0] bus_data,
	output logic [31:0] read_data,
	output logic overflow
);

	logic [31:0] store_q [NUM_VALUES];
	logic [NUM_VALUES-1:0] mark_q;
	logic [4:0] ring_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] count_q;
	logic act_valid_q;
	logic [4:0] act_idx_q;
	logic [31:0] act_data_q;
	logic [2:0] act_byte_q;
	logic [1:0] prof_q;
	logic [2:0] prec_q;
	logic ovalid_q;
	logic bvalid_q, ovf_q;
	logic [15:0] baddr_q, bdata_q;
	logic [31:0] rdata_q;

	logic q_full, do_it;
	logic [31:0] old_v, new_v;
	logic [7:0] mask, smask;
	logic [3:0] fwc;
	logic changed;
	logic [4:0] e_idx;
	logic [31:0] e_data;
	logic [2:0] e_byte, e_prec, e_len, e_next;
	logic [15:0] e_addr;
	logic [7:0] e_reg, e_dbyte;
	logic e_have;

	assign item_take = item_valid && (!ovalid_q || !out_stall);
	assign do_it = item_take && enable;
	assign q_full = (count_q >= QCNT_W'(QUEUE_DEPTH));

	// Bit-field and value update.
	always_comb begin
		old_v = store_q[item.idx_ok ? item.idx : 5'd0];
		fwc = (item.fw > 4'd8) ? 4'd8 : item.fw;
		mask = 8'hFF >> (4'd8 - fwc);
		smask = mask << item.flo;
		if (item.op == OP_FIELD) begin
			new_v = {24'd0, old_v[7:0] & ~smask} | (32'({24'd0, item.wv[7:0] & mask}) << item.flo);
		end else begin
			new_v = item.wv;
		end
		changed = (new_v != old_v);
	end

	// Emit: pick active word or queue head, then form the bus word.
	always_comb begin
		e_have = act_valid_q || (count_q != '0);
		e_prec = prec_q;
		if (act_valid_q) begin
			e_idx = act_idx_q;
			e_data = act_data_q;
			e_byte = act_byte_q;
		end else begin
			e_idx = (ring_q[head_q] < 5'(NUM_VALUES)) ? ring_q[head_q] : ring_q[head_q] - 5'd18;
			e_data = store_q[e_idx];
			e_len = val_len(e_idx);
			e_prec = (e_idx == 5'd6 || e_idx == 5'd8 || e_idx == 5'd10 || e_idx == 5'd12)
				? prec_q : e_len;
			e_byte = (e_len > e_prec) ? e_len - e_prec : 3'd0;
		end
		e_len = val_len(e_idx);
		e_addr = bus_offset + {6'd0, device_base, 2'b00};
		if (e_idx == IDX_UPDATE) e_addr = e_addr + 16'd2;
		else if (e_idx == IDX_ATTEN || e_idx == IDX_LATCH_STROBE) e_addr = e_addr + 16'd3;
		else if (e_idx != IDX_RESET_STROBE) e_addr = e_addr + 16'd1;
		e_reg = val_reg(e_idx) + {5'd0, e_byte} + (prof_q[1] ? 8'h80 : 8'h00)
			+ (prof_q[0] ? 8'h40 : 8'h00);
		e_dbyte = (e_byte < 3'd4) ? 8'(e_data >> {e_byte, 3'b000}) : 8'd0;
		e_next = e_byte + 3'd1;
		if (e_next >= e_len && e_idx != IDX_RESET_STROBE && e_idx != IDX_LATCH_STROBE
			&& e_idx != IDX_ATTEN) e_addr = e_addr + 16'd1;
	end

	// Ring memory writes (no reset: slots are written before they are read).
	// A master reset empties the ring, so its strobe lands in the first slot.
	always_ff @(posedge clk) begin
		if (do_it) begin
			case (item.op)
				OP_WRITE, OP_FIELD: begin
					if (item.idx_ok && changed && !q_full && !mark_q[item.idx])
						ring_q[tail_q] <= item.idx;
				end
				OP_MRESET: if (!q_full) ring_q['0] <= IDX_RESET_STROBE;
				OP_PROFILE: if (!q_full) ring_q[tail_q] <= IDX_LATCH_STROBE;
				default: ;
			endcase
		end
	end

	// Control and state updates plus the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VALUES; i++) store_q[i] <= '0;
			store_q[0] <= 32'h18;
			mark_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			act_valid_q <= 1'b0;
			act_idx_q <= '0;
			act_data_q <= '0;
			act_byte_q <= '0;
			prof_q <= '0;
			prec_q <= 3'd4;
			ovalid_q <= 1'b0;
			bvalid_q <= 1'b0;
			ovf_q <= 1'b0;
			baddr_q <= '0;
			bdata_q <= '0;
			rdata_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (item_take) begin
				ovalid_q <= 1'b1;
				bvalid_q <= 1'b0;
				ovf_q <= 1'b0;
				baddr_q <= '0;
				bdata_q <= '0;
				rdata_q <= '0;
			end
			if (do_it) begin
				case (item.op)
					OP_WRITE, OP_FIELD: begin
						if (item.idx_ok && changed) begin
							if (q_full) begin
								ovf_q <= 1'b1;
							end else begin
								store_q[item.idx] <= new_v;
								if (!mark_q[item.idx]) begin
									mark_q[item.idx] <= 1'b1;
									tail_q <= tail_q + 1'b1;
									count_q <= count_q + 1'b1;
								end
							end
						end
					end
					OP_READ: if (item.idx_ok) rdata_q <= old_v;
					OP_MRESET: begin
						if (q_full) begin
							ovf_q <= 1'b1;
						end else begin
							for (int i = 0; i < NUM_VALUES; i++) store_q[i] <= '0;
							store_q[0] <= 32'h18;
							mark_q <= '0;
							head_q <= '0;
							tail_q <= QPTR_W'(1);
							count_q <= QCNT_W'(1);
							act_valid_q <= 1'b0;
							act_idx_q <= '0;
							act_data_q <= '0;
							act_byte_q <= '0;
							prof_q <= '0;
							prec_q <= 3'd4;
						end
					end
					OP_PROFILE: begin
						prof_q[item.line] <= item.level;
						if (q_full) begin
							ovf_q <= 1'b1;
						end else begin
							tail_q <= tail_q + 1'b1;
							count_q <= count_q + 1'b1;
						end
					end
					OP_PREC: begin
						if (item.wv[7:0] > 8'd4) prec_q <= 3'd4;
						else if (item.wv[7:0] == 8'd0) prec_q <= 3'd1;
						else prec_q <= item.wv[2:0];
					end
					OP_EMIT: begin
						if (e_have) begin
							if (!act_valid_q) begin
								mark_q[e_idx] <= 1'b0;
								head_q <= head_q + 1'b1;
								count_q <= count_q - 1'b1;
							end
							act_idx_q <= e_idx;
							act_data_q <= e_data;
							if (e_next >= e_len) begin
								act_valid_q <= 1'b0;
								act_byte_q <= 3'd0;
							end else begin
								act_valid_q <= 1'b1;
								act_byte_q <= e_next;
							end
							bvalid_q <= 1'b1;
							baddr_q <= e_addr;
							bdata_q <= {e_dbyte, e_reg};
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = ovalid_q;
	assign bus_valid = bvalid_q;
	assign bus_address = baddr_q;
	assign bus_data = bdata_q;
	assign read_data = rdata_q;
	assign overflow = ovf_q;

endmodule

FILE: src/dds_shadow_register_write_queue.sv
// Top level of the shadow-register write queue with its configuration registers.
// Depends on dsrq_pkg, dsrq_front and dsrq_back.
//
// Usage: each input beat (in_valid/in_stall) carries one op; exactly one result
// beat (out_valid/out_stall) comes back per op, with bus_valid set for an emit
// that produced a bus word, read_data for a read and overflow when the ring was
// full. Configuration (enable, bus_offset, device_base) is written on the
// cfg_valid/cfg_ready channel, which is always ready; write it while idle.
// Path: a beat is registered in the front slot, then executed into the result
// register. Throughput: one op per cycle while the receiver does not stall;
// the back part executes each whole op against the flop-based shadow store
// and ring.
// Reset: arst_n restores the default values, empties the ring and enables the
// device. When the receiver stalls, the result holds, the front slot fills and
// then in_stall rises; nothing is dropped.
module dds_shadow_register_write_queue
	import dsrq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [4:0] value_index,
	input logic [31:0] write_value,
	input logic [2:0] field_low,
	input logic [3:0] field_width,
	input logic profile_line,
	input logic profile_level,
	output logic out_valid,
	input logic out_stall,
	output logic bus_valid,
	output logic [15:0] bus_address,
	output logic [15:0] bus_data,
	output logic [31:0] read_data,
	output logic overflow,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic enable_q;
	logic [15:0] bus_offset_q;
	logic [7:0] device_base_q;
	logic item_valid, item_take;
	item_t item;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			bus_offset_q <= '0;
			device_base_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_BUS_OFFSET: bus_offset_q <= cfg_data[15:0];
				CFG_DEVICE_BASE: device_base_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	dsrq_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .value_index, .write_value,
		.field_low, .field_width, .profile_line, .profile_level,
		.item_valid, .item, .item_take
	);

	dsrq_back u_back (
		.clk, .arst_n, .item_valid, .item, .item_take,
		.enable(enable_q), .bus_offset(bus_offset_q), .device_base(device_base_q),
		.out_valid, .out_stall, .bus_valid, .bus_address, .bus_data, .read_data, .overflow
	);

endmodule

FILE: src/dsrq_checker.sv
// Port-level checker for the shadow-register write queue, bound to the top level.
// Depends on nothing but the top level's ports.
module dsrq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic bus_valid,
	input logic [15:0] bus_data,
	input logic [31:0] read_data,
	input logic overflow
);

	// A stalled result beat keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// A bus word never comes with read data or overflow.
	a_bus_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_valid |-> read_data == 32'd0 && !overflow)
		else $error("bus word mixed with other results");

	// Bus data is zero without bus_valid.
	a_bus_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bus_valid |-> bus_data == 16'd0)
		else $error("bus data without bus word");

	// With no result pending the input is never stalled.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output idle");

endmodule

bind dds_shadow_register_write_queue dsrq_checker u_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.bus_valid, .bus_data, .read_data, .overflow
);

FILE: verif/dds_shadow_register_write_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for the shadow-register write queue: random and directed ops checked
// beat by beat against a behavioral model of the shadow store and its ring.
// Depends on dsrq_pkg and the dds_shadow_register_write_queue top level.
module dds_shadow_register_write_queue_tb;
	import dsrq_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [4:0] idx;
		logic [31:0] wv;
		logic [2:0] flo;
		logic [3:0] fw;
		logic line;
		logic level;
	} op_beat_t;

	typedef struct packed {
		logic bus_valid;
		logic [15:0] bus_address;
		logic [15:0] bus_data;
		logic [31:0] read_data;
		logic overflow;
	} bus_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = '0;
	logic [4:0] value_index = '0;
	logic [31:0] write_value = '0;
	logic [2:0] field_low = '0;
	logic [3:0] field_width = '0;
	logic profile_line = 1'b0;
	logic profile_level = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic bus_valid;
	logic [15:0] bus_address;
	logic [15:0] bus_data;
	logic [31:0] read_data;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	dds_shadow_register_write_queue u_top (.*);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state: configuration, shadow values and the ring.
	logic m_enable;
	logic [15:0] m_bus_offset;
	logic [7:0] m_device_base;
	logic [31:0] shadow [NUM_VALUES];
	logic queued [NUM_VALUES];
	logic [4:0] ring [$];
	logic word_busy;
	logic [4:0] word_idx;
	logic [31:0] word_contents;
	logic [2:0] word_byte;
	logic [1:0] profile_bits;
	logic [2:0] precision;

	op_beat_t pending_ops [$];
	bus_result_t expected_results [$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	bit idle_sender = 1'b1;
	bit idle_receiver = 1'b1;
	bit send_hold = 1'b0;
	int hold_cycles = 0;

	function automatic logic [2:0] byte_count(input logic [4:0] i);
		if (i inside {5'd4, 5'd6, 5'd8, 5'd10, 5'd12}) return 3'd4;
		if (i inside {5'd5, 5'd7, 5'd9, 5'd11, 5'd13}) return 3'd2;
		return 3'd1;
	endfunction

	function automatic logic [7:0] chip_reg(input logic [4:0] i);
		logic [7:0] regs [NUM_VALUES];
		regs = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'h0A, 8'h0E, 8'h10,
			8'h14, 8'h16, 8'h1A, 8'h1C, 8'h20, 8'h30, 8'h31, 8'h32, 8'h00};
		return regs[i];
	endfunction

	task automatic clear_shadow();
		for (int i = 0; i < NUM_VALUES; i++) begin
			shadow[i] = '0;
			queued[i] = 1'b0;
		end
		shadow[0] = 32'h18;
		ring.delete();
		word_busy = 1'b0;
		word_idx = '0;
		word_contents = '0;
		word_byte = '0;
		profile_bits = '0;
		precision = 3'd4;
	endtask

	// Store a value; returns 1 when the ring is full and the write is refused.
	function automatic logic store_shadow(input logic [4:0] i, input logic [31:0] v);
		if (shadow[i] == v) return 1'b0;
		if (ring.size() >= QUEUE_DEPTH) return 1'b1;
		shadow[i] = v;
		if (!queued[i]) begin
			queued[i] = 1'b1;
			ring.push_back(i);
		end
		return 1'b0;
	endfunction

	// Serialize the next byte of the value in progress onto a bus word.
	task automatic emit_bus_word(inout bus_result_t r);
		logic [15:0] addr;
		logic [7:0] rg;
		logic [7:0] data;
		logic [2:0] prec;
		if (!word_busy) begin
			if (ring.size() == 0) return;
			word_idx = ring.pop_front();
			word_contents = shadow[word_idx];
			prec = (word_idx inside {5'd6, 5'd8, 5'd10, 5'd12}) ? precision
				: byte_count(word_idx);
			word_byte = (byte_count(word_idx) > prec) ? byte_count(word_idx) - prec : 3'd0;
			queued[word_idx] = 1'b0;
			word_busy = 1'b1;
		end
		addr = m_bus_offset + {6'd0, m_device_base, 2'b00};
		if (word_idx == IDX_UPDATE) addr += 16'd2;
		else if (word_idx == IDX_ATTEN || word_idx == IDX_LATCH_STROBE) addr += 16'd3;
		else if (word_idx != IDX_RESET_STROBE) addr += 16'd1;
		rg = chip_reg(word_idx) + {5'd0, word_byte};
		if (profile_bits[1]) rg += 8'h80;
		if (profile_bits[0]) rg += 8'h40;
		data = (word_byte < 3'd4) ? word_contents[8 * word_byte +: 8] : 8'h00;
		word_byte = word_byte + 3'd1;
		if (word_byte >= byte_count(word_idx)) begin
			if (!(word_idx inside {IDX_RESET_STROBE, IDX_LATCH_STROBE, IDX_ATTEN}))
				addr += 16'd1;
			word_busy = 1'b0;
			word_byte = '0;
		end
		r.bus_valid = 1'b1;
		r.bus_address = addr;
		r.bus_data = {data, rg};
	endtask

	// Predict the result of one op and advance the model.
	task automatic predict_op(input op_beat_t b);
		bus_result_t r;
		logic [3:0] fw;
		logic [7:0] mask;
		logic [7:0] smask;
		logic [31:0] nv;
		logic [7:0] p;
		r = '0;
		if (m_enable) begin
			case (op_t'(b.op))
				OP_WRITE: if (b.idx < NUM_VALUES) r.overflow = store_shadow(b.idx, b.wv);
				OP_FIELD: if (b.idx < NUM_VALUES) begin
					fw = (b.fw > 4'd8) ? 4'd8 : b.fw;
					mask = 8'hFF >> (8 - fw);
					smask = mask << b.flo;
					nv = {24'd0, shadow[b.idx][7:0] & ~smask}
						| ({24'd0, b.wv[7:0] & mask} << b.flo);
					r.overflow = store_shadow(b.idx, nv);
				end
				OP_READ: if (b.idx < NUM_VALUES) r.read_data = shadow[b.idx];
				OP_MRESET: if (ring.size() >= QUEUE_DEPTH) r.overflow = 1'b1;
				else begin
					clear_shadow();
					ring.push_back(IDX_RESET_STROBE);
				end
				OP_PROFILE: begin
					profile_bits[b.line] = b.level;
					if (ring.size() >= QUEUE_DEPTH) r.overflow = 1'b1;
					else ring.push_back(IDX_LATCH_STROBE);
				end
				OP_PREC: begin
					p = b.wv[7:0];
					precision = (p > 8'd4) ? 3'd4 : (p < 8'd1) ? 3'd1 : p[2:0];
				end
				OP_EMIT: emit_bus_word(r);
				default: ;
			endcase
		end
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("error: result %0d %s got %h expected %h", received, what, got, want);
		errors++;
	endtask

	// Driver: presents queued ops, idles at random unless idle_sender is set, and holds while send_hold is on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_op('{op, value_index, write_value, field_low, field_width,
					profile_line, profile_level});
				sent++;
			end
			if ((in_valid && !in_stall) || !in_valid) begin
				if (pending_ops.size() != 0 && !send_hold
					&& (idle_sender || $urandom_range(99) >= 15)) begin
					op_beat_t b;
					b = pending_ops.pop_front();
					in_valid <= 1'b1;
					{op, value_index, write_value, field_low, field_width,
						profile_line, profile_level} <= b;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !idle_receiver && $urandom_range(99) < 15;
	end

	// Monitor: compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			bus_result_t w;
			if (expected_results.size() == 0) begin
				$display("error: result %0d with nothing expected", received);
				errors++;
			end else begin
				w = expected_results.pop_front();
				if (bus_valid !== w.bus_valid) report_mismatch("bus_valid", bus_valid, w.bus_valid);
				if (bus_address !== w.bus_address)
					report_mismatch("bus_address", bus_address, w.bus_address);
				if (bus_data !== w.bus_data) report_mismatch("bus_data", bus_data, w.bus_data);
				if (read_data !== w.read_data) report_mismatch("read_data", read_data, w.read_data);
				if (overflow !== w.overflow) report_mismatch("overflow", overflow, w.overflow);
			end
			received++;
		end
	end

	function automatic op_beat_t rand_op(input int write_bias);
		op_beat_t b;
		b.op = $urandom_range(99) < write_bias ? 3'($urandom_range(1)) : 3'($urandom_range(7));
		b.idx = $urandom_range(99) < 90 ? 5'($urandom_range(17)) : 5'($urandom_range(31));
		b.wv = $urandom_range(1) ? $urandom : 32'($urandom_range(255));
		if (b.op == OP_PREC && $urandom_range(1)) b.wv = $urandom_range(6);
		b.flo = 3'($urandom_range(7));
		b.fw = 4'($urandom_range(15));
		b.line = 1'($urandom_range(1));
		b.level = 1'($urandom_range(1));
		return b;
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ENABLE: m_enable = v[0];
			CFG_BUS_OFFSET: m_bus_offset = v[15:0];
			default: m_device_base = v[7:0];
		endcase
	endtask

	// Stimulus: directed ops, then random phases under several settings.
	initial begin
		op_beat_t b;
		m_enable = 1'b1;
		m_bus_offset = '0;
		m_device_base = '0;
		clear_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every op, field widths 0 and 15, bad index, strobes.
		b = '0;
		b.op = OP_READ; pending_ops.push_back(b);
		b.op = OP_WRITE; b.idx = 5'd6; b.wv = 32'hFFFF_FFFF; pending_ops.push_back(b);
		b.op = OP_WRITE; pending_ops.push_back(b);
		b.op = OP_FIELD; b.idx = 5'd4; b.wv = 32'hFF; b.flo = 3'd7; b.fw = 4'd15;
		pending_ops.push_back(b);
		b.fw = 4'd0; b.flo = 3'd0; pending_ops.push_back(b);
		b.op = OP_WRITE; b.idx = 5'd31; pending_ops.push_back(b);
		b.op = OP_READ; pending_ops.push_back(b);
		b.op = OP_PREC; b.wv = 32'h0; pending_ops.push_back(b);
		b.op = OP_EMIT; pending_ops.push_back(b);
		b.op = OP_PREC; b.wv = 32'hFF; pending_ops.push_back(b);
		b.op = OP_PROFILE; b.line = 1'b1; b.level = 1'b1; pending_ops.push_back(b);
		b.line = 1'b0; pending_ops.push_back(b);
		for (int i = 0; i < 8; i++) begin
			b.op = OP_EMIT; pending_ops.push_back(b);
		end
		b.op = OP_MRESET; pending_ops.push_back(b);
		b.op = OP_NONE; pending_ops.push_back(b);
		b.op = OP_EMIT; pending_ops.push_back(b);
		pending_ops.push_back(b);
		b.op = OP_READ; b.idx = 5'd17; pending_ops.push_back(b);
		wait_drained();

		for (int phase = 0; phase < 7; phase++) begin
			idle_sender = (phase == 1);
			idle_receiver = (phase == 1);
			case (phase)
				1: begin write_cfg(CFG_BUS_OFFSET, 32'hFFFF); write_cfg(CFG_DEVICE_BASE, 32'hFF); end
				2: write_cfg(CFG_ENABLE, 32'h0);
				3: begin write_cfg(CFG_ENABLE, 32'h1); write_cfg(CFG_BUS_OFFSET, $urandom); end
				4: write_cfg(CFG_DEVICE_BASE, $urandom);
				5: begin write_cfg(CFG_BUS_OFFSET, 32'h0); write_cfg(CFG_DEVICE_BASE, 32'h0); end
				default: ;
			endcase
			// Phase 4 fills the ring with mostly writes and few emits to reach overflow.
			for (int i = 0; i < 200; i++)
				pending_ops.push_back(phase == 4 && i < 120 ? rand_op(95) : rand_op(40));
			if (phase == 3) hold_cycles = 300;
			if (phase == 5) begin
				// Pause the sender until every expected result has come.
				while (pending_ops.size() > 100) @(posedge clk);
				send_hold = 1'b1;
				while (in_valid || expected_results.size() != 0) @(posedge clk);
				send_hold = 1'b0;
			end
			wait_drained();
		end
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("dds_shadow_register_write_queue: match");
		else
			$display("dds_shadow_register_write_queue: mismatch");
		$finish;
	end

	// Timeout guard.
	initial begin
		#5ms;
		$display("dds_shadow_register_write_queue: mismatch");
		$finish;
	end

endmodule

FILE: files.f
src/dsrq_pkg.sv
src/dsrq_front.sv
src/dsrq_back.sv
src/dds_shadow_register_write_queue.sv
src/dsrq_checker.sv
verif/dds_shadow_register_write_queue_tb.sv
